[hdl/wspl_pkg.sv]
// Shared types, constants and saturation helpers for the wheel speed PID loop.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package wspl_pkg;

   localparam int WSPL_WHEELS = 6;
   localparam int WSPL_PPR    = 8192;

   localparam int RPM_NUM  = 60000;
   localparam int DEN_W    = 49;
   localparam int REM_W    = DEN_W + 1;
   localparam int QUO_W    = 46;
   localparam int STEP_W   = 6;
   localparam int DERIV_STEPS = 32;
   localparam int MAG_W    = 48;
   localparam int PROD_W   = 64;
   localparam int SUM_W    = 52;

   localparam logic [31:0] PROP_GAIN_RST  = 32'd42949673;
   localparam logic [31:0] INTEG_GAIN_RST = 32'd121118;
   localparam logic [31:0] DERIV_GAIN_RST = 32'd0;
   localparam logic [15:0] SPEED_LIM_RST  = 16'd600;
   localparam logic [15:0] DUTY_LIM_RST   = 16'd32768;

   typedef enum logic [2:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_INTEG_GAIN = 3'd1,
      CSR_DERIV_GAIN = 3'd2,
      CSR_SPEED_LIM  = 3'd3,
      CSR_DUTY_LIM   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] prev_error;
      logic signed [47:0] error_integral;
      logic signed [47:0] accum_output;
      logic               dir_bit;
   } wheel_state_type;

   typedef struct packed {
      logic              start;
      logic [REM_W-1:0]  r_init;
      logic [QUO_W-1:0]  bits;
      logic [STEP_W-1:0] steps;
      logic [DEN_W-1:0]  den;
   } div_req_type;

   function automatic logic signed [47:0] sat48(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = 52'sh0_7FFF_FFFF_FFFF;
      lo = -hi - 52'sd1;
      if (v > hi) begin
         return 48'sh7FFF_FFFF_FFFF;
      end else if (v < lo) begin
         return 48'sh8000_0000_0000;
      end
      return v[47:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [47:0] hi;
      logic signed [47:0] lo;
      hi = 48'sh0000_7FFF_FFFF;
      lo = -hi - 48'sd1;
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

`default_nettype wire

[hdl/wspl_state_mem.sv]
// Per-wheel controller state memory with a registered read.
// Entries not yet written read as zero. Depends on wspl_pkg.
`default_nettype none

module wspl_state_mem #(
   parameter int WHEELS = 6,
   localparam int AW = (WHEELS > 1) ? $clog2(WHEELS) : 1
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      rd_en,
   input  wire  [AW-1:0]            rd_addr,
   output wspl_pkg::wheel_state_type rd_data,
   input  wire                      wr_en,
   input  wire  [AW-1:0]            wr_addr,
   input  wspl_pkg::wheel_state_type wr_data
);
   import wspl_pkg::*;

   wheel_state_type mem_ff [WHEELS];
   wheel_state_type rd_data_ff;
   logic [WHEELS-1:0] valid_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

[hdl/wspl_div.sv]
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on wspl_pkg for widths and the request struct.
`default_nettype none

module wspl_div (
   input  wire                     clock,
   input  wire                     reset,
   input  wspl_pkg::div_req_type   req,
   output logic                    busy,
   output logic [wspl_pkg::QUO_W-1:0] quot
);
   import wspl_pkg::*;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  bits_ff, bits_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [REM_W-1:0]  rem_shift;
   logic              ge;

   always_comb begin
      rem_shift = {rem_ff[REM_W-2:0], bits_ff[QUO_W-1]};
      ge        = rem_shift >= {1'b0, den_ff};
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      bits_in   = bits_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.steps;
         rem_in  = req.r_init;
         bits_in = req.bits;
         quo_in  = '0;
         den_in  = req.den;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_shift - {1'b0, den_ff} : rem_shift;
         bits_in = {bits_ff[QUO_W-2:0], 1'b0};
         quo_in  = {quo_ff[QUO_W-2:0], ge};
         cnt_in  = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
   end

   assign busy = busy_ff;
   assign quot = quo_ff;

endmodule

`default_nettype wire

[hdl/wheel_speed_pid_loop.sv]
// Top level of the wheel speed PID loop: sequencer, datapath and registers.
// Depends on wspl_pkg, wspl_state_mem and wspl_div.
//
// Usage: one request word names a wheel and carries its rpm command, encoder
// pulse count and elapsed milliseconds; one response word per request returns
// the wheel, the clamped duty and the direction. Both channels use valid and
// ready. Requests are handled one at a time: for each, the bit-serial divider
// runs two ratio divisions of 46 quotient bits and one derivative division of
// 32 quotient bits, and the 48x16 multiplier makes a low and a high pass for
// each of the three gain terms. The next request can be accepted once the
// response appears. A request for a wheel number at or above WHEELS skips
// this work and gives its response with duty and direction 0. The response
// sits in an output register; the next request is accepted while it waits,
// and the sequencer holds the following result until it is taken. Per-wheel
// state lives in a small memory read on acceptance and written back when the
// result is issued. Reset clears all wheel state to zero and restores the
// register defaults; no clearing pass is needed. Registers are written
// through csr_we, csr_index and csr_wdata; the user must write them only
// while idle, which the block itself does not enforce.
`default_nettype none

module wheel_speed_pid_loop #(
   parameter int WHEELS         = wspl_pkg::WSPL_WHEELS,
   parameter int PULSES_PER_REV = wspl_pkg::WSPL_PPR
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire        [2:0]  req_wheel,
   input  wire signed [15:0] req_command_rpm,
   input  wire signed [23:0] req_pulse_count,
   input  wire        [15:0] req_elapsed_ms,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic       [2:0]  rsp_wheel_out,
   output logic       [15:0] rsp_duty,
   output logic              rsp_direction,
   input  wire               csr_we,
   input  wire        [2:0]  csr_index,
   input  wire        [31:0] csr_wdata
);
   import wspl_pkg::*;

   localparam int AW = (WHEELS > 1) ? $clog2(WHEELS) : 1;

   typedef enum logic [15:0] {
      ST_IDLE  = 16'h0001,
      ST_READ  = 16'h0002,
      ST_DEN   = 16'h0004,
      ST_TGO   = 16'h0008,
      ST_TWAIT = 16'h0010,
      ST_MGO   = 16'h0020,
      ST_MWAIT = 16'h0040,
      ST_PREP  = 16'h0080,
      ST_DDIV  = 16'h0100,
      ST_INTEG = 16'h0200,
      ST_DWAIT = 16'h0400,
      ST_MSEL  = 16'h0800,
      ST_MLO   = 16'h1000,
      ST_MHI   = 16'h2000,
      ST_MACC  = 16'h4000,
      ST_FIN   = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [15:0] speed_limit_ff, duty_limit_ff;

   logic [2:0]         wheel_ff, wheel_in;
   logic signed [15:0] cmd_ff, cmd_in;
   logic signed [23:0] pul_ff, pul_in;
   logic [15:0]        dt_ff, dt_in;
   logic               oor_ff, oor_in;
   wheel_state_type    st_ff, st_in;
   logic [31:0]        dtlim_ff, dtlim_in;
   logic [39:0]        num_ff, num_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [QUO_W-1:0]   tgt_ff, tgt_in;
   logic               cap_ff, cap_in;
   logic signed [31:0] err_ff, err_in;
   logic [32:0]        sum_mag_ff, sum_mag_in;
   logic               sum_neg_ff, sum_neg_in;
   logic [31:0]        dif_mag_ff, dif_mag_in;
   logic               dif_neg_ff, dif_neg_in;
   logic signed [47:0] integ_ff, integ_in;
   logic signed [32:0] deriv_ff, deriv_in;
   logic [1:0]         idx_ff, idx_in;
   logic [MAG_W-1:0]   m_ff, m_in;
   logic               mneg_ff, mneg_in;
   logic [MAG_W-1:0]   lo_t_ff, lo_t_in;
   logic [PROD_W-1:0]  mul_p_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_wheel_ff, rsp_wheel_in;
   logic [15:0]        rsp_duty_ff, rsp_duty_in;
   logic               rsp_dir_ff, rsp_dir_in;

   logic [MAG_W-1:0]   mul_a;
   logic [15:0]        mul_b;
   div_req_type        div_req;
   logic               div_busy;
   logic [QUO_W-1:0]   div_quot;
   logic               mem_rd_en, mem_wr_en;
   wheel_state_type    mem_rd_data, mem_wr_data;

   logic        accept;
   logic        in_range;
   logic [15:0] lim;
   logic [15:0] acmd;
   logic [23:0] apul;
   logic        cmd_zero;
   logic [31:0] gain;
   logic [46:0] meas;
   logic signed [47:0] ediff;
   logic signed [33:0] psum, psum_abs;
   logic signed [32:0] pdif, pdif_abs;
   logic [47:0] dmag;
   logic signed [SUM_W-1:0] ival;
   logic signed [32:0] dq;
   logic signed [48:0] xsel, xabs;
   logic [64:0] tsum;
   logic [48:0] term;
   logic signed [47:0] outv;
   logic signed [47:0] dlim;
   logic [15:0] duty;
   logic        dir_new;
   logic        out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_range  = 32'(req_wheel) < 32'(WHEELS);
   assign lim       = (speed_limit_ff == 16'd0) ? 16'd1 : speed_limit_ff;
   assign acmd      = cmd_ff[15] ? 16'(-cmd_ff) : 16'(cmd_ff);
   assign apul      = pul_ff[23] ? 24'(-pul_ff) : 24'(pul_ff);
   assign cmd_zero  = (cmd_ff == 16'sd0);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= PROP_GAIN_RST;
         integ_gain_ff  <= INTEG_GAIN_RST;
         deriv_gain_ff  <= DERIV_GAIN_RST;
         speed_limit_ff <= SPEED_LIM_RST;
         duty_limit_ff  <= DUTY_LIM_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PROP_GAIN:  prop_gain_ff   <= csr_wdata;
            CSR_INTEG_GAIN: integ_gain_ff  <= csr_wdata;
            CSR_DERIV_GAIN: deriv_gain_ff  <= csr_wdata;
            CSR_SPEED_LIM:  speed_limit_ff <= csr_wdata[15:0];
            CSR_DUTY_LIM:   duty_limit_ff  <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (idx_ff)
         2'd0:    gain = prop_gain_ff;
         2'd1:    gain = integ_gain_ff;
         default: gain = deriv_gain_ff;
      endcase
      case (idx_ff)
         2'd0:    xsel = 49'(err_ff);
         2'd1:    xsel = 49'(integ_ff);
         default: xsel = 49'(deriv_ff);
      endcase
      xabs = xsel[48] ? -xsel : xsel;

      case (state_ff)
         ST_DDIV: begin
            mul_a = MAG_W'(sum_mag_ff);
            mul_b = dt_ff;
         end
         ST_MLO: begin
            mul_a = m_ff;
            mul_b = gain[15:0];
         end
         ST_MHI: begin
            mul_a = m_ff;
            mul_b = gain[31:16];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase

      meas     = cap_ff ? 47'h4000_0000_0000 : {1'b0, div_quot};
      ediff    = $signed({2'b00, tgt_ff}) - $signed({1'b0, meas});
      psum     = 34'(err_ff) + 34'(st_ff.prev_error);
      psum_abs = psum[33] ? -psum : psum;
      pdif     = 33'(err_ff) - 33'(st_ff.prev_error);
      pdif_abs = pdif[32] ? -pdif : pdif;
      dmag     = mul_p_ff[48:1];
      ival     = sum_neg_ff ? SUM_W'(st_ff.error_integral) - $signed({4'b0, dmag})
                            : SUM_W'(st_ff.error_integral) + $signed({4'b0, dmag});
      dq       = $signed({1'b0, div_quot[31:0]});
      tsum     = {1'b0, mul_p_ff} + 65'(lo_t_ff);
      term     = tsum[64:16];

      outv     = cmd_zero ? 48'sd0 : sat48(sum_ff);
      dlim     = $signed({18'b0, duty_limit_ff, 14'b0});
      if (outv > dlim) begin
         duty = duty_limit_ff;
      end else if (outv < 48'sd0) begin
         duty = 16'd0;
      end else begin
         duty = outv[29:14];
      end
      if (cmd_ff > 16'sd0) begin
         dir_new = 1'b1;
      end else if (cmd_ff < 16'sd0) begin
         dir_new = 1'b0;
      end else begin
         dir_new = st_ff.dir_bit;
      end

      mem_wr_data.prev_error     = cmd_zero ? 32'sd0 : err_ff;
      mem_wr_data.error_integral = cmd_zero ? 48'sd0 : integ_ff;
      mem_wr_data.accum_output   = outv;
      mem_wr_data.dir_bit        = dir_new;
   end

   always_comb begin
      state_in     = state_ff;
      wheel_in     = wheel_ff;
      cmd_in       = cmd_ff;
      pul_in       = pul_ff;
      dt_in        = dt_ff;
      oor_in       = oor_ff;
      st_in        = st_ff;
      dtlim_in     = dtlim_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      tgt_in       = tgt_ff;
      cap_in       = cap_ff;
      err_in       = err_ff;
      sum_mag_in   = sum_mag_ff;
      sum_neg_in   = sum_neg_ff;
      dif_mag_in   = dif_mag_ff;
      dif_neg_in   = dif_neg_ff;
      integ_in     = integ_ff;
      deriv_in     = deriv_ff;
      idx_in       = idx_ff;
      m_in         = m_ff;
      mneg_in      = mneg_ff;
      lo_t_in      = lo_t_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_wheel_in = rsp_wheel_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_dir_in   = rsp_dir_ff;
      div_req      = '0;
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wheel_in  = req_wheel;
               cmd_in    = req_command_rpm;
               pul_in    = req_pulse_count;
               dt_in     = (req_elapsed_ms == 16'd0) ? 16'd1 : req_elapsed_ms;
               oor_in    = !in_range;
               mem_rd_en = in_range;
               state_in  = in_range ? ST_READ : ST_FIN;
            end
         end
         ST_READ: begin
            st_in    = mem_rd_data;
            dtlim_in = 32'(dt_ff) * 32'(lim);
            num_in   = 40'(RPM_NUM) * 40'(apul);
            state_in = ST_DEN;
         end
         ST_DEN: begin
            den_in   = DEN_W'(dtlim_ff) * DEN_W'(PULSES_PER_REV);
            state_in = ST_TGO;
         end
         ST_TGO: begin
            div_req.start  = 1'b1;
            div_req.r_init = '0;
            div_req.bits   = {acmd, 30'b0};
            div_req.steps  = STEP_W'(QUO_W);
            div_req.den    = DEN_W'(lim);
            state_in       = ST_TWAIT;
         end
         ST_TWAIT: begin
            if (!div_busy) begin
               tgt_in   = div_quot;
               state_in = ST_MGO;
            end
         end
         ST_MGO: begin
            div_req.start  = 1'b1;
            div_req.r_init = REM_W'(num_ff[39:16]);
            div_req.bits   = {num_ff[15:0], 30'b0};
            div_req.steps  = STEP_W'(QUO_W);
            div_req.den    = den_ff;
            cap_in         = 65'(num_ff) >= {den_ff, 16'b0};
            state_in       = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (!div_busy) begin
               err_in   = sat32(ediff);
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            sum_neg_in = psum[33];
            sum_mag_in = psum_abs[32:0];
            dif_neg_in = pdif[32];
            dif_mag_in = pdif_abs[31:0];
            state_in   = ST_DDIV;
         end
         ST_DDIV: begin
            div_req.start  = 1'b1;
            div_req.r_init = '0;
            div_req.bits   = {dif_mag_ff, 14'b0};
            div_req.steps  = STEP_W'(DERIV_STEPS);
            div_req.den    = DEN_W'(dt_ff);
            state_in       = ST_INTEG;
         end
         ST_INTEG: begin
            integ_in = sat48(ival);
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (!div_busy) begin
               deriv_in = dif_neg_ff ? -dq : dq;
               sum_in   = SUM_W'(st_ff.accum_output);
               idx_in   = 2'd0;
               state_in = ST_MSEL;
            end
         end
         ST_MSEL: begin
            m_in     = xabs[47:0];
            mneg_in  = xsel[48];
            state_in = ST_MLO;
         end
         ST_MLO: begin
            state_in = ST_MHI;
         end
         ST_MHI: begin
            lo_t_in  = mul_p_ff[63:16];
            state_in = ST_MACC;
         end
         ST_MACC: begin
            sum_in = mneg_ff ? sum_ff - $signed({3'b0, term})
                             : sum_ff + $signed({3'b0, term});
            if (idx_ff == 2'd2) begin
               state_in = ST_FIN;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_MSEL;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_wheel_in = wheel_ff;
               rsp_duty_in  = oor_ff ? 16'd0 : duty;
               rsp_dir_in   = oor_ff ? 1'b0 : dir_new;
               mem_wr_en    = !oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wheel_ff     <= wheel_in;
      cmd_ff       <= cmd_in;
      pul_ff       <= pul_in;
      dt_ff        <= dt_in;
      oor_ff       <= oor_in;
      st_ff        <= st_in;
      dtlim_ff     <= dtlim_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      tgt_ff       <= tgt_in;
      cap_ff       <= cap_in;
      err_ff       <= err_in;
      sum_mag_ff   <= sum_mag_in;
      sum_neg_ff   <= sum_neg_in;
      dif_mag_ff   <= dif_mag_in;
      dif_neg_ff   <= dif_neg_in;
      integ_ff     <= integ_in;
      deriv_ff     <= deriv_in;
      idx_ff       <= idx_in;
      m_ff         <= m_in;
      mneg_ff      <= mneg_in;
      lo_t_ff      <= lo_t_in;
      mul_p_ff     <= mul_a * PROD_W'(mul_b);
      sum_ff       <= sum_in;
      rsp_wheel_ff <= rsp_wheel_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_dir_ff   <= rsp_dir_in;
   end

   wspl_state_mem #(
      .WHEELS (WHEELS)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (AW'(req_wheel)),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (AW'(wheel_ff)),
      .wr_data (mem_wr_data)
   );

   wspl_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_wheel_out = rsp_wheel_ff;
   assign rsp_duty      = rsp_duty_ff;
   assign rsp_direction = rsp_dir_ff;

endmodule

`default_nettype wire

[hdl/wspl_checker.sv]
// Port-level checks for the wheel speed PID loop, bound to its top level.
// Depends on wspl_pkg and wheel_speed_pid_loop.
`default_nettype none

module wspl_checker #(
   parameter int WHEELS = wspl_pkg::WSPL_WHEELS
) (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [2:0]  rsp_wheel_out,
   input wire [15:0] rsp_duty,
   input wire        rsp_direction,
   input wire        csr_we,
   input wire [2:0]  csr_index,
   input wire [31:0] csr_wdata
);
   import wspl_pkg::*;

   logic [15:0] duty_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_lim_ff <= DUTY_LIM_RST;
      end else if (csr_we && (csr_index == CSR_DUTY_LIM)) begin
         duty_lim_ff <= csr_wdata[15:0];
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_duty) && $stable(rsp_direction)
                                  && $stable(rsp_wheel_out))
      else $error("response word changed while stalled");

   a_duty_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty <= duty_lim_ff)
      else $error("duty above the duty limit");

   a_bad_wheel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (32'(rsp_wheel_out) >= 32'(WHEELS))
      |-> rsp_duty == 16'd0 && !rsp_direction)
      else $error("unknown wheel produced a drive word");

endmodule

bind wheel_speed_pid_loop wspl_checker #(.WHEELS(WHEELS)) u_wspl_checker (.*);

`default_nettype wire
